/* rtl/tick_tock_phase_timer_macros.svh */
// Assertion macros used by the checker file.
`ifndef TICK_TOCK_PHASE_TIMER_MACROS_SVH
`define TICK_TOCK_PHASE_TIMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define TTPT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tick_tock_phase_timer: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while reset is low.
`define TTPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tick_tock_phase_timer: next-cycle check failed");

`endif

/* rtl/ttpt_pkg.sv */
package ttpt_pkg;

    localparam int INTERVAL_W = 22;
    localparam int FREQ_W     = 17;
    localparam int COUNT_W    = 23;
    localparam int PEND_W     = 24;
    localparam int SHIFT_W    = 21;
    localparam int REQ_W      = 2;
    localparam int EV_W       = 2;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    localparam int TICKS_PER_US_DEF = 5;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(20000);
    localparam logic [COUNT_W-1:0]    COUNT_MAX    = '1;
    localparam logic signed [PEND_W-1:0] PEND_MAX  = {1'b0, {(PEND_W-1){1'b1}}};
    localparam logic signed [PEND_W-1:0] PEND_MIN  = {1'b1, {(PEND_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 2'd0,
        REQ_SHIFT  = 2'd1,
        REQ_STOP   = 2'd2,
        REQ_RESUME = 2'd3
    } req_t;

    typedef enum logic [EV_W-1:0] {
        EV_NONE = 2'd0,
        EV_TICK = 2'd1,
        EV_TOCK = 2'd2
    } event_t;

endpackage

/* rtl/ttpt_shift_scale.sv */
module ttpt_shift_scale #(
    parameter int TICKS_PER_US = ttpt_pkg::TICKS_PER_US_DEF
) (
    input  logic [ttpt_pkg::INTERVAL_W-1:0]    interval_ticks,
    input  logic signed [ttpt_pkg::SHIFT_W-1:0] shift_value,
    output logic signed [ttpt_pkg::PEND_W-1:0]  shift_ticks
);
    import ttpt_pkg::*;

    localparam int LIM_W  = INTERVAL_W - 2;
    localparam int CLMP_W = SHIFT_W + 1;
    localparam int TPU_W  = $clog2(TICKS_PER_US + 1);
    localparam int PROD_W = CLMP_W + TPU_W + 1;

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(PEND_MAX);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(PEND_MIN);
    localparam logic signed [PROD_W-1:0] SCALE  =
        $signed(PROD_W'({1'b0, TPU_W'(TICKS_PER_US)}));

    logic signed [CLMP_W-1:0] shift_ext;
    logic signed [CLMP_W-1:0] lim_pos;
    logic signed [CLMP_W-1:0] lim_neg;
    logic signed [CLMP_W-1:0] shift_clamped;
    logic signed [PROD_W-1:0] product;

    // Limit is a quarter of the interval tick count, applied to the shift in microseconds
    assign lim_pos   = $signed(CLMP_W'(interval_ticks[INTERVAL_W-1 -: LIM_W]));
    assign lim_neg   = -lim_pos;
    assign shift_ext = CLMP_W'(shift_value);

    always_comb
    begin
        if (shift_ext > lim_pos)
        begin
            shift_clamped = lim_pos;
        end
        else if (shift_ext < lim_neg)
        begin
            shift_clamped = lim_neg;
        end
        else
        begin
            shift_clamped = shift_ext;
        end
    end

    assign product = PROD_W'(shift_clamped) * SCALE;

    always_comb
    begin
        if (product > SAT_HI)
        begin
            shift_ticks = PEND_MAX;
        end
        else if (product < SAT_LO)
        begin
            shift_ticks = PEND_MIN;
        end
        else
        begin
            shift_ticks = product[PEND_W-1:0];
        end
    end

endmodule

/* rtl/tick_tock_phase_timer.sv */
// Tick/tock phase timer. Each input transaction is one timer tick, a phase shift
// request, a stop or a resume, and produces exactly one result transaction carrying
// the event raised (none, tick or tock) and whether the timer is running. The block
// takes one transaction per clock cycle while the downstream takes results; the input
// register captures a transaction when it is accepted and the result register loads
// its result when the transaction advances. The whole update of countdown, phase and
// pending shift is done combinationally between them. While the result register is
// held by a stalled downstream, the input register still takes one more transaction.
// Configuration writes are always ready and take effect at the next reload or phase
// shift request; write them only while idle.
module tick_tock_phase_timer #(
    parameter int TICKS_PER_US = ttpt_pkg::TICKS_PER_US_DEF
) (
    input  logic clk,
    input  logic rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [20:0] shift_value, [23:21] zero
    input  logic [ttpt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] req_type
    input  logic [ttpt_pkg::REQ_W-1:0]         s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] event_res, [2] active, [7:3] zero
    output logic [ttpt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ttpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ttpt_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ttpt_pkg::*;

    localparam int SUM_W = PEND_W + 2;
    localparam logic signed [SUM_W-1:0] SUM_CNT_MAX = $signed(SUM_W'(COUNT_MAX));

    // configuration
    logic [INTERVAL_W-1:0]    interval_reg;
    logic signed [FREQ_W-1:0] freq_offset_reg;
    logic                     tx_mode_reg;

    // input stage
    logic                     in_valid_reg;
    req_t                     req_reg;
    logic signed [SHIFT_W-1:0] shift_reg;

    // timer state
    logic                     run_reg,       run_next;
    logic                     phase_reg,     phase_next;
    logic [COUNT_W-1:0]       count_reg,     count_next;
    logic signed [PEND_W-1:0] pend_reg,      pend_next;

    // result stage
    logic                     out_valid_reg;
    event_t                   event_reg,     event_next;
    logic                     active_reg;

    logic                     advance;
    logic signed [PEND_W-1:0] shift_ticks;
    logic signed [SUM_W-1:0]  period_base;
    logic signed [SUM_W-1:0]  pend_term;
    logic signed [SUM_W-1:0]  period_sum;
    logic [COUNT_W-1:0]       period_load;
    logic [COUNT_W-1:0]       interval_load;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({active_reg, event_reg});

    ttpt_shift_scale #(
        .TICKS_PER_US (TICKS_PER_US)
    ) u_shift_scale (
        .interval_ticks (interval_reg),
        .shift_value    (shift_reg),
        .shift_ticks    (shift_ticks)
    );

    // Half interval plus offset, plus the pending shift ahead of a tick
    assign period_base = $signed(SUM_W'({1'b0, interval_reg[INTERVAL_W-1:1]}))
                         + SUM_W'(freq_offset_reg);
    assign pend_term   = phase_reg ? '0 : SUM_W'(pend_reg);
    assign period_sum  = period_base + pend_term;

    always_comb
    begin
        if (period_sum <= 0)
        begin
            period_load = COUNT_W'(1);
        end
        else if (period_sum > SUM_CNT_MAX)
        begin
            period_load = COUNT_MAX;
        end
        else
        begin
            period_load = period_sum[COUNT_W-1:0];
        end
    end

    assign interval_load = (interval_reg == '0) ? COUNT_W'(1) : COUNT_W'(interval_reg);

    always_comb
    begin
        run_next   = run_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        event_next = EV_NONE;

        unique case (req_reg)
            REQ_TICK:
            begin
                if (run_reg)
                begin
                    if (count_reg <= COUNT_W'(1))
                    begin
                        if (tx_mode_reg)
                        begin
                            count_next = interval_load;
                            event_next = EV_TOCK;
                        end
                        else
                        begin
                            count_next = period_load;
                            phase_next = !phase_reg;
                            if (phase_reg)
                            begin
                                event_next = EV_TICK;
                            end
                            else
                            begin
                                event_next = EV_TOCK;
                                pend_next  = '0;
                            end
                        end
                    end
                    else
                    begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
            end
            REQ_SHIFT:
            begin
                pend_next = shift_ticks;
            end
            REQ_STOP:
            begin
                run_next = 1'b0;
            end
            REQ_RESUME:
            begin
                if (!run_reg)
                begin
                    run_next = 1'b1;
                    if (tx_mode_reg)
                    begin
                        count_next = interval_load;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        count_next = COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg    <= INTERVAL_RST;
            freq_offset_reg <= '0;
            tx_mode_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INTERVAL: interval_reg    <= cfg_data[INTERVAL_W-1:0];
                CFG_FREQ:     freq_offset_reg <= $signed(cfg_data[FREQ_W-1:0]);
                CFG_MODE:     tx_mode_reg     <= cfg_data[0];
                default:      tx_mode_reg     <= tx_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            count_reg     <= COUNT_W'(INTERVAL_RST);
            pend_reg      <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                run_reg       <= run_next;
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                pend_reg      <= pend_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            req_reg   <= req_t'(s_axis_tuser);
            shift_reg <= $signed(s_axis_tdata[SHIFT_W-1:0]);
        end
        if (advance)
        begin
            event_reg  <= event_next;
            active_reg <= run_next;
        end
    end

endmodule

/* rtl/ttpt_checker.sv */
`include "tick_tock_phase_timer_macros.svh"

module ttpt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ttpt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);
    import ttpt_pkg::*;

    logic [EV_W-1:0] ev_field;
    logic            active_field;

    assign ev_field     = m_axis_tdata[EV_W-1:0];
    assign active_field = m_axis_tdata[EV_W];

    // An expiry only happens while the timer runs
    `TTPT_ASSERT_IMPL(a_event_needs_active, m_axis_tvalid && (ev_field != EV_NONE), active_field)

    // Input is only held off while a result is waiting
    `TTPT_ASSERT_IMPL(a_stall_only_when_full, !s_axis_tready, m_axis_tvalid)

    // Configuration writes are never back-pressured
    `TTPT_ASSERT_IMPL(a_cfg_always_ready, cfg_valid, cfg_ready)

    // A stalled result holds
    `TTPT_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
                      m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind tick_tock_phase_timer ttpt_checker u_ttpt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);
